FILE: hw/rtl/fsda_pkg.sv
package fsda_pkg;

  localparam int SampleW  = 16;
  localparam int CfgW     = 16;
  localparam int SumW     = 32;
  localparam int TotalW   = CfgW + 1;
  localparam int CntW     = 6;

  localparam logic [CntW-1:0] STEP_BITS = CntW'(TotalW);
  localparam logic [CntW-1:0] MEAN_BITS = CntW'(SumW);

  // configuration register indexes
  localparam logic REG_IN_PER_SEG  = 1'b0;
  localparam logic REG_OUT_PER_SEG = 1'b1;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/fractional_step_decimating_averager.sv
// Fractional-rate boxcar decimator: averages runs of consecutive signed samples
// so that every segment of input samples (register 0) yields the configured
// number of averages (register 1). Run lengths follow an exact rational phase
// accumulator (remainder kept in units of the output count), and each finished
// run yields its sum divided by its length, truncated toward zero.
// start_of_data clears the phase and the partial run; a trailing partial run is
// never emitted. Both divisions go through one shared restoring divider that
// retires one quotient bit per cycle: the run-length step when a sample opens a
// run, and the mean when a sample closes a run.
// in_ready is low while an item is worked.
// A finished average sits in the output register while the next sample is
// taken; the block only waits for out_ready when a second average is done.
// Configuration writes are always taken (cfg_ready high) and apply when the
// next run starts.
module fractional_step_decimating_averager (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fsda_pkg::SampleW-1:0] in_sample,
  input  logic                              in_start_of_data,
  // average channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fsda_pkg::SampleW-1:0] out_average,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [fsda_pkg::CfgW-1:0]         cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_ACC,
    ST_MEAN,
    ST_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [fsda_pkg::CfgW-1:0] in_per_seg_r;
  logic [fsda_pkg::CfgW-1:0] out_per_seg_r;

  // run state
  logic [fsda_pkg::CfgW-1:0] phase_r;
  logic [fsda_pkg::CfgW-1:0] run_length_r;
  logic [fsda_pkg::CfgW-1:0] run_count_r;
  logic [fsda_pkg::SumW-1:0] run_sum_r;

  // item and result holding
  logic [fsda_pkg::SampleW-1:0] sample_r;
  logic                         neg_r;
  logic [fsda_pkg::SampleW-1:0] avg_r;
  logic [fsda_pkg::SampleW-1:0] out_average_r;
  logic                         out_valid_r;

  // combinational
  logic                        in_xfer;
  logic                        new_run;
  logic [fsda_pkg::CfgW-1:0]   seg_eff;
  logic [fsda_pkg::CfgW-1:0]   samp_eff;
  logic [fsda_pkg::TotalW-1:0] total;
  logic [fsda_pkg::SumW-1:0]   sum_add;
  logic [fsda_pkg::CfgW:0]     cnt_inc;
  logic                        run_done;
  logic [fsda_pkg::SumW-1:0]   sum_mag;

  fsda_pkg::div_req_t          div_req;
  fsda_pkg::div_stat_t         div_stat;
  logic [fsda_pkg::SumW-1:0]   div_dividend;
  logic [fsda_pkg::CfgW-1:0]   div_divisor;
  logic [fsda_pkg::SumW-1:0]   div_quo;
  logic [fsda_pkg::CfgW-1:0]   div_rem;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_xfer     = in_valid && in_ready;
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  always_comb begin
    // zero registers act as one, sampling size never above segment size
    seg_eff  = (in_per_seg_r == '0) ? fsda_pkg::CfgW'(1) : in_per_seg_r;
    samp_eff = (out_per_seg_r == '0) ? fsda_pkg::CfgW'(1) : out_per_seg_r;
    if (samp_eff > seg_eff) begin
      samp_eff = seg_eff;
    end
    // start flag clears phase and partial run before the sample is used
    new_run = in_start_of_data || (run_count_r == '0);
    total   = {1'b0, (in_start_of_data ? fsda_pkg::CfgW'(0) : phase_r)} + {1'b0, seg_eff};

    // accumulate the held sample, sign extended
    sum_add  = run_sum_r + {{(fsda_pkg::SumW-fsda_pkg::SampleW){sample_r[fsda_pkg::SampleW-1]}},
                            sample_r};
    cnt_inc  = {1'b0, run_count_r} + 1'b1;
    run_done = cnt_inc >= {1'b0, run_length_r};
    sum_mag  = sum_add[fsda_pkg::SumW-1] ? (~sum_add + 1'b1) : sum_add;
  end

  // divider requests: run-length step from idle, mean from accumulate
  always_comb begin
    div_req.start = 1'b0;
    div_req.nbits = fsda_pkg::STEP_BITS;
    div_dividend  = {total, {(fsda_pkg::SumW-fsda_pkg::TotalW){1'b0}}};
    div_divisor   = samp_eff;
    case (state_r)
      ST_IDLE: begin
        div_req.start = in_xfer && new_run;
      end
      ST_ACC: begin
        div_req.start = run_done;
        div_req.nbits = fsda_pkg::MEAN_BITS;
        div_dividend  = sum_mag;
        div_divisor   = run_length_r;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  fsda_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // configuration registers, taken at any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_per_seg_r  <= fsda_pkg::CfgW'(1);
      out_per_seg_r <= fsda_pkg::CfgW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        fsda_pkg::REG_IN_PER_SEG:  in_per_seg_r  <= cfg_data;
        fsda_pkg::REG_OUT_PER_SEG: out_per_seg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= '0;
      run_length_r <= '0;
      run_count_r  <= '0;
      run_sum_r    <= '0;
      neg_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // the emit state keeps or refills the output register itself
      if (out_valid_r && out_ready && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            sample_r <= in_sample;
            if (in_start_of_data) begin
              phase_r     <= '0;
              run_count_r <= '0;
              run_sum_r   <= '0;
            end
            state_r <= new_run ? ST_STEP : ST_ACC;
          end
        end
        ST_STEP: begin
          // quotient is the run length, saturated; the residue is the new phase
          if (div_stat.done) begin
            phase_r      <= div_rem;
            run_length_r <= (div_quo[fsda_pkg::TotalW-1:fsda_pkg::CfgW] != '0) ? '1 :
                            (div_quo[fsda_pkg::CfgW-1:0] == '0) ? fsda_pkg::CfgW'(1) :
                            div_quo[fsda_pkg::CfgW-1:0];
            run_count_r  <= '0;
            run_sum_r    <= '0;
            state_r      <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (run_done) begin
            neg_r       <= sum_add[fsda_pkg::SumW-1];
            run_count_r <= '0;
            run_sum_r   <= '0;
            state_r     <= ST_MEAN;
          end else begin
            run_count_r <= cnt_inc[fsda_pkg::CfgW-1:0];
            run_sum_r   <= sum_add;
            state_r     <= ST_IDLE;
          end
        end
        ST_MEAN: begin
          // magnitude quotient, sign restored, kept to sample width
          if (div_stat.done) begin
            avg_r   <= neg_r ? (~div_quo[fsda_pkg::SampleW-1:0] + 1'b1)
                             : div_quo[fsda_pkg::SampleW-1:0];
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_average_r <= avg_r;
            out_valid_r   <= 1'b1;
            state_r       <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/fsda_div.sv
module fsda_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fsda_pkg::div_req_t                req,
  input  logic [fsda_pkg::SumW-1:0]         dividend,
  input  logic [fsda_pkg::CfgW-1:0]         divisor,
  output fsda_pkg::div_stat_t               stat,
  output logic [fsda_pkg::SumW-1:0]         quotient,
  output logic [fsda_pkg::CfgW-1:0]         remainder
);

  logic [fsda_pkg::SumW-1:0] quo_r;
  logic [fsda_pkg::CfgW-1:0] rem_r;
  logic [fsda_pkg::CfgW-1:0] den_r;
  logic [fsda_pkg::CntW-1:0] cnt_r;
  logic                      done_r;

  logic [fsda_pkg::CfgW:0]   rem_sh;
  logic [fsda_pkg::CfgW:0]   diff;
  logic                      fits;
  logic [fsda_pkg::CfgW-1:0] rem_nxt;

  // one restoring step: bring down the next dividend bit, try a subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[fsda_pkg::SumW-1]};
    diff    = rem_sh - {1'b0, den_r};
    fits    = rem_sh >= {1'b0, den_r};
    rem_nxt = fits ? diff[fsda_pkg::CfgW-1:0] : rem_sh[fsda_pkg::CfgW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        quo_r <= dividend;
        rem_r <= '0;
        den_r <= divisor;
        cnt_r <= req.nbits;
      end else if (cnt_r != '0) begin
        quo_r  <= {quo_r[fsda_pkg::SumW-2:0], fits};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == fsda_pkg::CntW'(1));
      end
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
